// ===== hw/rtl/jsru_pkg.sv =====
package jsru_pkg;

	localparam int FRAC_BITS_DEF = 32;
	localparam int WORD_W        = 64;
	localparam int ACC_W         = 68;

	// configuration register indexes
	localparam logic [1:0] REG_TWO_G  = 2'd0;
	localparam logic [1:0] REG_LAMBDA = 2'd1;
	localparam logic [1:0] REG_DT     = 2'd2;

	localparam logic [62:0] DT_RESET = 63'd4295;
	localparam logic [3:0]  LAST_IDX = 4'd8;

	function automatic logic [1:0] row_of(input logic [3:0] e);
		logic [1:0] r;
		begin
			case (e) inside
				4'd3, 4'd4, 4'd5: r = 2'd1;
				4'd6, 4'd7, 4'd8: r = 2'd2;
				default:          r = 2'd0;
			endcase
			return r;
		end
	endfunction

	function automatic logic [1:0] col_of(input logic [3:0] e);
		logic [1:0] c;
		begin
			case (e) inside
				4'd1, 4'd4, 4'd7: c = 2'd1;
				4'd2, 4'd5, 4'd8: c = 2'd2;
				default:          c = 2'd0;
			endcase
			return c;
		end
	endfunction

	function automatic logic [3:0] idx_of(input logic [1:0] r, input logic [1:0] c);
		return {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
	endfunction

	// index of the transposed element
	function automatic logic [3:0] tp_of(input logic [3:0] e);
		return idx_of(col_of(e), row_of(e));
	endfunction

	function automatic logic [63:0] sat_acc(input logic [ACC_W-1:0] a);
		logic [63:0] v;
		begin
			if (a[ACC_W-1:63] == {(ACC_W-63){a[63]}})
				v = a[63:0];
			else if (a[ACC_W-1])
				v = {1'b1, 63'd0};
			else
				v = {1'b0, {63{1'b1}}};
			return v;
		end
	endfunction

endpackage

// ===== hw/rtl/jsru_mul.sv =====
module jsru_mul #(
	parameter int FRAC_BITS = jsru_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] result
);

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [65:0]  pp_q;
	logic [1:0]   sh_q;
	logic [2:0]   ph_q;
	logic         busy_q, done_q;
	logic [63:0]  result_q;

	logic signed [32:0]  opa, opb;
	logic signed [65:0]  pp;
	logic [127:0]        pp_ext, pp_shifted;
	logic signed [127:0] shifted;
	logic [63:0]         sat_v;

	// one 33x33 partial product per cycle: low*low, low*high, high*low, high*high
	always_comb begin
		case (ph_q[1:0])
			2'd0: begin
				opa = {1'b0, a_q[31:0]};
				opb = {1'b0, b_q[31:0]};
			end
			2'd1: begin
				opa = {1'b0, a_q[31:0]};
				opb = {b_q[63], b_q[63:32]};
			end
			2'd2: begin
				opa = {a_q[63], a_q[63:32]};
				opb = {1'b0, b_q[31:0]};
			end
			default: begin
				opa = {a_q[63], a_q[63:32]};
				opb = {b_q[63], b_q[63:32]};
			end
		endcase
		pp = opa * opb;
		pp_ext = {{62{pp_q[65]}}, pp_q};
		case (sh_q)
			2'd0:    pp_shifted = pp_ext;
			2'd1:    pp_shifted = pp_ext << 32;
			default: pp_shifted = pp_ext << 64;
		endcase
		shifted = $signed(acc_q) >>> FRAC_BITS;
		if (shifted[127:63] == {65{shifted[63]}})
			sat_v = shifted[63:0];
		else if (acc_q[127])
			sat_v = {1'b1, 63'd0};
		else
			sat_v = {1'b0, {63{1'b1}}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ph_q   <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= 3'd0;
			end else if (busy_q) begin
				ph_q <= ph_q + 3'd1;
				if (ph_q == 3'd5) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (ph_q < 3'd4) begin
				pp_q <= pp;
				sh_q <= (ph_q == 3'd0) ? 2'd0 : ((ph_q == 3'd3) ? 2'd2 : 2'd1);
			end
			if (ph_q >= 3'd1 && ph_q <= 3'd4)
				acc_q <= acc_q + pp_shifted;
			if (ph_q == 3'd5)
				result_q <= sat_v;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== hw/rtl/jaumann_stress_rate_update_top.sv =====
// after the item with component 8, nine results follow, for an active particle or an
// inactive one, delayed further by result stalls
// throughput: one item per cycle while loading, then no item until the particle is done;
// set by the shared 64x64 multiplier (73 products per particle)
// reset: configuration registers take their reset values, active flag and control clear
module jaumann_stress_rate_update_top #(
	parameter int FRAC_BITS = jsru_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [3:0]  component,
	input  logic [63:0] grad_value,
	input  logic [63:0] stress_value,
	input  logic        active,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [3:0]  out_component,
	output logic [63:0] new_stress,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_HALF0  = 4'd1;
	localparam logic [3:0] ST_HALF1  = 4'd2;
	localparam logic [3:0] ST_TRACE  = 4'd3;
	localparam logic [3:0] ST_TRMUL  = 4'd4;
	localparam logic [3:0] ST_TRWAIT = 4'd5;
	localparam logic [3:0] ST_TERM   = 4'd6;
	localparam logic [3:0] ST_TWAIT  = 4'd7;
	localparam logic [3:0] ST_RSAVE  = 4'd8;
	localparam logic [3:0] ST_OMUL   = 4'd9;
	localparam logic [3:0] ST_OWAIT  = 4'd10;
	localparam logic [3:0] ST_OEMIT  = 4'd11;
	localparam logic [3:0] ST_PASS   = 4'd12;

	localparam int AW = jsru_pkg::ACC_W;

	logic [3:0]  state_q;
	logic [3:0]  e_q;
	logic [2:0]  t_q;
	logic        active_q;
	logic [62:0] two_g_q, dt_q;
	logic [63:0] lam_q;
	logic [63:0] x_q, trlam_q, ns_q;
	logic [AW-1:0] acc_q;

	logic [63:0] grad_q   [9];
	logic [63:0] stress_q [9];
	logic [63:0] d_q      [9];
	logic [63:0] w_q      [9];
	logic [63:0] r_q      [9];

	logic        out_valid_q, out_last_q;
	logic [3:0]  out_comp_q;
	logic [63:0] out_stress_q;

	logic        accept, out_free;
	logic [1:0]  ri, ci, k;
	logic [3:0]  grad_ra, stress_ra, d_ra, w_ra;
	logic [63:0] grad_rd, stress_rd, d_rd, w_rd;
	logic [64:0] sum, diff, ns_sum;
	logic        mul_start, mul_done;
	logic [63:0] mul_a, mul_b, mul_res;
	logic [AW-1:0] mul_ext;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign out_free   = !out_valid_q || !result_stall;

	always_comb begin
		ri = jsru_pkg::row_of(e_q);
		ci = jsru_pkg::col_of(e_q);
		k  = (t_q < 3'd5) ? 2'(t_q - 3'd2) : 2'(t_q - 3'd5);
		grad_ra = (state_q == ST_HALF1) ? jsru_pkg::tp_of(e_q) : e_q;
		d_ra    = (state_q == ST_TRACE) ? {e_q[1:0], 2'b00} : e_q;
		if (t_q < 3'd5) begin
			w_ra      = jsru_pkg::idx_of(ri, k);
			stress_ra = jsru_pkg::idx_of(k, ci);
		end else begin
			w_ra      = jsru_pkg::idx_of(k, ci);
			stress_ra = jsru_pkg::idx_of(ri, k);
		end
		if (state_q != ST_TERM)
			stress_ra = e_q;
		grad_rd   = grad_q[grad_ra];
		stress_rd = stress_q[stress_ra];
		d_rd      = d_q[d_ra];
		w_rd      = w_q[w_ra];
		sum  = {x_q[63], x_q} + {grad_rd[63], grad_rd};
		diff = {x_q[63], x_q} - {grad_rd[63], grad_rd};
		mul_ext = {{(AW-64){mul_res[63]}}, mul_res};
		ns_sum = {stress_rd[63], stress_rd} + {mul_res[63], mul_res};

		mul_start = 1'b0;
		mul_a = {1'b0, two_g_q};
		mul_b = d_rd;
		unique case (state_q)
			ST_TERM: begin
				mul_start = (t_q != 3'd1);
				if (t_q == 3'd0) begin
					mul_a = {1'b0, two_g_q};
					mul_b = d_rd;
				end else if (t_q < 3'd5) begin
					mul_a = w_rd;
					mul_b = stress_rd;
				end else begin
					mul_a = stress_rd;
					mul_b = w_rd;
				end
			end
			ST_TRMUL: begin
				mul_start = 1'b1;
				mul_a = lam_q;
				mul_b = jsru_pkg::sat_acc(acc_q);
			end
			ST_OMUL: begin
				mul_start = 1'b1;
				mul_a = {1'b0, dt_q};
				mul_b = r_q[jsru_pkg::tp_of(e_q)];
			end
			default: begin
				mul_start = 1'b0;
			end
		endcase
	end

	jsru_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.result (mul_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_g_q <= '0;
			lam_q   <= '0;
			dt_q    <= jsru_pkg::DT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				jsru_pkg::REG_TWO_G:  two_g_q <= cfg_data[62:0];
				jsru_pkg::REG_LAMBDA: lam_q   <= cfg_data;
				jsru_pkg::REG_DT:     dt_q    <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && component <= jsru_pkg::LAST_IDX) begin
			grad_q[component]   <= grad_value;
			stress_q[component] <= stress_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			e_q         <= '0;
			t_q         <= '0;
			active_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result register loads only from the emit states
			if (out_free)
				out_valid_q <= (state_q == ST_OEMIT || state_q == ST_PASS);
			unique case (state_q) inside
				ST_IDLE: begin
					if (accept && component == jsru_pkg::LAST_IDX) begin
						active_q <= active;
						e_q      <= '0;
						state_q  <= active ? ST_HALF0 : ST_PASS;
					end
				end
				ST_HALF0: state_q <= ST_HALF1;
				ST_HALF1: begin
					if (e_q == jsru_pkg::LAST_IDX) begin
						e_q     <= '0;
						state_q <= ST_TRACE;
					end else begin
						e_q     <= e_q + 4'd1;
						state_q <= ST_HALF0;
					end
				end
				ST_TRACE: begin
					if (e_q == 4'd2) begin
						e_q     <= '0;
						state_q <= ST_TRMUL;
					end else begin
						e_q <= e_q + 4'd1;
					end
				end
				ST_TRMUL: state_q <= ST_TRWAIT;
				ST_TRWAIT: begin
					if (mul_done) begin
						t_q     <= '0;
						state_q <= ST_TERM;
					end
				end
				ST_TERM: begin
					if (t_q == 3'd1)
						t_q <= 3'd2;
					else
						state_q <= ST_TWAIT;
				end
				ST_TWAIT: begin
					if (mul_done) begin
						if (t_q == 3'd7) begin
							state_q <= ST_RSAVE;
						end else begin
							t_q     <= t_q + 3'd1;
							state_q <= ST_TERM;
						end
					end
				end
				ST_RSAVE: begin
					t_q <= '0;
					if (e_q == jsru_pkg::LAST_IDX) begin
						e_q     <= '0;
						state_q <= ST_OMUL;
					end else begin
						e_q     <= e_q + 4'd1;
						state_q <= ST_TERM;
					end
				end
				ST_OMUL: state_q <= ST_OWAIT;
				ST_OWAIT: begin
					if (mul_done)
						state_q <= ST_OEMIT;
				end
				ST_OEMIT, ST_PASS: begin
					if (out_free) begin
						if (e_q == jsru_pkg::LAST_IDX) begin
							e_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							e_q     <= e_q + 4'd1;
							state_q <= active_q ? ST_OMUL : ST_PASS;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q) inside
			ST_HALF0: x_q <= grad_rd;
			ST_HALF1: begin
				d_q[e_q] <= sum[64:1];
				w_q[e_q] <= diff[64:1];
				acc_q    <= '0;
			end
			ST_TRACE: acc_q <= acc_q + {{(AW-64){d_rd[63]}}, d_rd};
			ST_TRWAIT: begin
				if (mul_done) begin
					trlam_q <= mul_res;
					acc_q   <= '0;
				end
			end
			ST_TERM: begin
				if (t_q == 3'd1 && ri == ci)
					acc_q <= acc_q + {{(AW-64){trlam_q[63]}}, trlam_q};
			end
			ST_TWAIT: begin
				if (mul_done) begin
					if (t_q >= 3'd5)
						acc_q <= acc_q - mul_ext;
					else
						acc_q <= acc_q + mul_ext;
				end
			end
			ST_RSAVE: begin
				r_q[e_q] <= jsru_pkg::sat_acc(acc_q);
				acc_q    <= '0;
			end
			ST_OWAIT: begin
				if (mul_done)
					ns_q <= jsru_pkg::sat_acc({{(AW-65){ns_sum[64]}}, ns_sum});
			end
			ST_OEMIT, ST_PASS: begin
				if (out_free) begin
					out_comp_q   <= e_q;
					out_last_q   <= (e_q == jsru_pkg::LAST_IDX);
					out_stress_q <= active_q ? ns_q : stress_rd;
				end
			end
			default: ;
		endcase
	end

	assign result_valid  = out_valid_q;
	assign out_component = out_comp_q;
	assign new_stress    = out_stress_q;
	assign last          = out_last_q;

`ifndef SYNTHESIS
	a_last_is_eight: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> out_component == jsru_pkg::LAST_IDX)
		else $error("last result without component 8");

	a_comp_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> out_component <= jsru_pkg::LAST_IDX)
		else $error("result component out of range");

	a_busy_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && component == jsru_pkg::LAST_IDX |=> item_stall)
		else $error("particle closed but block still takes items");

	a_done_expected: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_TWAIT || state_q == ST_TRWAIT || state_q == ST_OWAIT))
		else $error("product finished with nobody waiting");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int FRAC = jsru_pkg::FRAC_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 700;

	typedef struct packed {
		logic [3:0]  comp;
		logic [63:0] grad;
		logic [63:0] stress;
		logic        act;
	} particle_item_t;

	typedef struct packed {
		logic [3:0]  comp;
		logic [63:0] stress;
		logic        last;
	} stress_result_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [3:0]  component;
	logic [63:0] grad_value;
	logic [63:0] stress_value;
	logic        active;
	logic        result_valid;
	logic        result_stall;
	logic [3:0]  out_component;
	logic [63:0] new_stress;
	logic        last;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [63:0] cfg_data;

	jaumann_stress_rate_update_top u_top (.*);

	particle_item_t pending_items[$];
	stress_result_t expected_stress[$];

	// mirror of the block state
	logic [62:0] m_two_g;
	logic [63:0] m_lambda;
	logic [62:0] m_dt;
	logic [63:0] grad_mem[9];
	logic [63:0] stress_mem[9];
	logic        act_flag;

	int send_idle_pct;
	int recv_stall_pct;
	int errors;
	int cycles;
	int accepted_n;
	int driven_n;

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = 1'b1;
			#4 clk = 1'b0;
		end
	end

	function automatic logic signed [63:0] sat72(input logic signed [71:0] s);
		if (s[71:63] == {9{s[63]}})
			return s[63:0];
		return s[71] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
	endfunction

	function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [127:0] p;
		p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
		p = p >>> FRAC;
		if (p[127:63] == {65{p[63]}})
			return p[63:0];
		return p[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
	endfunction

	function automatic logic signed [63:0] halve(input logic signed [63:0] a,
			input logic signed [63:0] b, input logic sub);
		logic signed [64:0] s;
		s = sub ? ($signed({a[63], a}) - $signed({b[63], b}))
		        : ($signed({a[63], a}) + $signed({b[63], b}));
		return s[64:1];
	endfunction

	task automatic update_stress(input particle_item_t it);
		logic signed [63:0] dm[9];
		logic signed [63:0] wm[9];
		logic signed [63:0] rm[9];
		logic signed [63:0] tm[9];
		logic signed [63:0] tr_lam;
		logic signed [71:0] acc;
		stress_result_t res;
		int i, j, k;
		if (it.comp > jsru_pkg::LAST_IDX)
			return;
		grad_mem[it.comp] = it.grad;
		stress_mem[it.comp] = it.stress;
		if (it.comp != jsru_pkg::LAST_IDX)
			return;
		act_flag = it.act;
		for (i = 0; i < 9; i++)
			tm[i] = stress_mem[i];
		if (act_flag) begin
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++) begin
					dm[3*i+j] = halve(grad_mem[3*i+j], grad_mem[3*j+i], 1'b0);
					wm[3*i+j] = halve(grad_mem[3*i+j], grad_mem[3*j+i], 1'b1);
				end
			acc = 72'sd0;
			acc = acc + dm[0] + dm[4] + dm[8];
			tr_lam = fx_mul(m_lambda, sat72(acc));
			for (i = 0; i < 3; i++)
				for (j = 0; j < 3; j++) begin
					acc = 72'sd0;
					acc = acc + fx_mul({1'b0, m_two_g}, dm[3*i+j]);
					if (i == j)
						acc = acc + tr_lam;
					for (k = 0; k < 3; k++) begin
						acc = acc + fx_mul(wm[3*i+k], tm[3*k+j]);
						acc = acc - fx_mul(tm[3*i+k], wm[3*k+j]);
					end
					rm[3*i+j] = sat72(acc);
				end
		end
		for (i = 0; i < 9; i++) begin
			res.comp = i[3:0];
			res.last = (i == 8);
			res.stress = tm[i];
			if (act_flag) begin
				acc = 72'sd0;
				// transpose: element r,c takes rate c,r
				acc = acc + tm[i] + fx_mul({1'b0, m_dt}, rm[3*(i%3) + i/3]);
				res.stress = sat72(acc);
			end
			expected_stress.push_back(res);
		end
	endtask

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return {1'b0, {63{1'b1}}};
			1: return {1'b1, 63'd0};
			2: return 64'd0;
			3, 4: return {$urandom, $urandom};
			5, 6: return {{30{$urandom_range(0, 1) == 1}}, 2'b0, $urandom};
			default: return {{28{$urandom_range(0, 1) == 1}}, 4'($urandom_range(0, 15)),
				$urandom};
		endcase
	endfunction

	task automatic push_item(input logic [3:0] c, input logic a);
		particle_item_t it;
		it.comp = c;
		it.grad = pick_word();
		it.stress = pick_word();
		it.act = a;
		pending_items.push_back(it);
	endtask

	task automatic push_particle(input bit full);
		int order[8];
		int i, j, t;
		for (i = 0; i < 8; i++)
			order[i] = i;
		for (i = 7; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = order[i]; order[i] = order[j]; order[j] = t;
		end
		for (i = 0; i < 8; i++) begin
			if (!full && $urandom_range(0, 2) == 0)
				continue;
			if ($urandom_range(0, 15) == 0)
				push_item(4'($urandom_range(9, 15)), 1'($urandom_range(0, 1)));
			push_item(4'(order[i]), 1'($urandom_range(0, 1)));
		end
		push_item(jsru_pkg::LAST_IDX, $urandom_range(0, 7) != 0);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == jsru_pkg::REG_TWO_G)
			m_two_g = val[62:0];
		else if (idx == jsru_pkg::REG_LAMBDA)
			m_lambda = val;
		else if (idx == jsru_pkg::REG_DT)
			m_dt = val[62:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || expected_stress.size() != 0 ||
				accepted_n != driven_n)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		particle_item_t it;
		int ph, n, i;
		arst_n = 1'b0;
		item_valid = 1'b0;
		component = 4'd0;
		grad_value = 64'd0;
		stress_value = 64'd0;
		active = 1'b0;
		result_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = jsru_pkg::REG_TWO_G;
		cfg_data = 64'd0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		m_two_g = 63'd0;
		m_lambda = 64'd0;
		m_dt = jsru_pkg::DT_RESET;
		act_flag = 1'b0;
		for (i = 0; i < 9; i++) begin
			grad_mem[i] = 64'd0;
			stress_mem[i] = 64'd0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// first particle at reset values, every element written
		for (i = 0; i < 9; i++) begin
			it.comp = i[3:0];
			it.grad = (i % 2) ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
			it.stress = (i % 3 == 0) ? {1'b1, 63'd0} : 64'(i) << 32;
			it.act = 1'b1;
			pending_items.push_back(it);
		end
		wait_idle();

		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
				default: begin send_idle_pct = 36; recv_stall_pct = 36; end
			endcase
			case (ph)
				0: begin
					write_reg(jsru_pkg::REG_TWO_G, 64'd2 << 32);
					write_reg(jsru_pkg::REG_LAMBDA, 64'd1 << 32);
					write_reg(jsru_pkg::REG_DT, 64'd1 << 22);
					write_reg(2'd3, {$urandom, $urandom});
				end
				1: begin
					write_reg(jsru_pkg::REG_TWO_G, {1'b1, {63{1'b1}}});
					write_reg(jsru_pkg::REG_LAMBDA, {1'b1, 63'd0});
					write_reg(jsru_pkg::REG_DT, {1'b0, {63{1'b1}}});
				end
				2: begin
					write_reg(jsru_pkg::REG_TWO_G, 64'd0);
					write_reg(jsru_pkg::REG_LAMBDA, 64'd0);
					write_reg(jsru_pkg::REG_DT, 64'd0);
				end
				3: begin
					write_reg(jsru_pkg::REG_LAMBDA, {1'b0, {63{1'b1}}});
					write_reg(jsru_pkg::REG_DT, 64'd1 << 32);
				end
				default: begin
					write_reg(jsru_pkg::REG_TWO_G, {$urandom, $urandom});
					write_reg(jsru_pkg::REG_LAMBDA, {{24{$urandom_range(0, 1) == 1}},
						8'($urandom), $urandom});
					write_reg(jsru_pkg::REG_DT, {32'd0, $urandom});
				end
			endcase
			if (ph == 0) begin
				// ignored indexes, inactive early completion, active early completion
				push_item(4'd15, 1'b1);
				push_item(4'd9, 1'b0);
				push_item(4'd4, 1'b1);
				push_item(jsru_pkg::LAST_IDX, 1'b0);
				push_item(4'd1, 1'b0);
				push_item(jsru_pkg::LAST_IDX, 1'b1);
				push_item(jsru_pkg::LAST_IDX, 1'b1);
			end
			n = 0;
			while (n < 38) begin
				push_particle($urandom_range(0, 2) != 0);
				n = pending_items.size();
				if (pending_items.size() == 0)
					n = 38;
				wait_idle();
				n = n + 0;
				break;
			end
			for (i = 0; i < 4; i++)
				push_particle($urandom_range(0, 2) != 0);
			wait_idle();
		end

		if (errors == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && !(item_valid && accepted_n != driven_n)) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				particle_item_t it;
				it = pending_items.pop_front();
				item_valid <= 1'b1;
				component <= it.comp;
				grad_value <= it.grad;
				stress_value <= it.stress;
				active <= it.act;
				driven_n <= driven_n + 1;
			end else begin
				item_valid <= 1'b0;
			end
		end
		result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// input acceptance and prediction
	always @(posedge clk) begin
		particle_item_t it;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
		if (item_valid && !item_stall) begin
			it.comp = component;
			it.grad = grad_value;
			it.stress = stress_value;
			it.act = active;
			update_stress(it);
			accepted_n <= accepted_n + 1;
		end
	end

	// result monitor
	always @(posedge clk) begin
		stress_result_t e;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_stress.size() == 0) begin
				$error("unexpected result out_component=%0d new_stress=%h", out_component,
					new_stress);
				errors = errors + 1;
			end else begin
				e = expected_stress.pop_front();
				if (out_component !== e.comp) begin
					$error("out_component expected %0d actual %0d", e.comp, out_component);
					errors = errors + 1;
				end
				if (new_stress !== e.stress) begin
					$error("new_stress expected %h actual %h", e.stress, new_stress);
					errors = errors + 1;
				end
				if (last !== e.last) begin
					$error("last expected %0b actual %0b", e.last, last);
					errors = errors + 1;
				end
			end
		end
	end

	initial begin
		errors = 0;
		cycles = 0;
		accepted_n = 0;
		driven_n = 0;
	end

endmodule
